>>> hw/rtl/cpfr_pkg.sv
package cpfr_pkg;

   // Positions inside a packet.
   localparam logic [10:0] POS_MAGIC_LO      = 11'd0;
   localparam logic [10:0] POS_MAGIC_HI      = 11'd1;
   localparam logic [10:0] POS_CHANNEL       = 11'd2;
   localparam logic [10:0] POS_LENGTH_LO     = 11'd3;
   localparam logic [10:0] POS_LENGTH_HI     = 11'd4;
   localparam logic [10:0] POS_FRAME_ID      = 11'd5;
   localparam logic [10:0] POS_CAMERA        = 11'd6;
   localparam logic [10:0] POS_FLAGS         = 11'd7;
   localparam logic [10:0] POS_PAYLOAD_START = 11'd12;
   localparam logic [10:0] POS_SATURATE      = 11'h7FF;

   localparam logic [7:0]  MAGIC_LO          = 8'hAA;
   localparam logic [7:0]  MAGIC_HI          = 8'hBB;
   localparam logic [7:0]  CHANNEL_A         = 8'd7;
   localparam logic [7:0]  CHANNEL_B         = 8'd11;
   localparam logic [7:0]  CAMERA_LIMIT      = 8'd2;
   localparam logic [7:0]  FLAG_REJECT_MASK  = 8'hFD;
   localparam int          FLAG_BUTTON_BIT   = 1;
   localparam logic [15:0] MIN_STATED_LENGTH = 16'd7;
   localparam logic [16:0] TRANSPORT_BYTES   = 17'd5;
   localparam logic [10:0] MIN_PACKET_SIZE   = 11'd12;
   localparam logic [10:0] MAX_PACKET        = 11'h400;

   localparam logic        CMD_BYTE          = 1'b0;
   localparam logic        CMD_FLUSH         = 1'b1;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_FRAME_END = 2'd1,
      KIND_BUTTON    = 2'd2
   } kind_type;

   // Everything one input byte produces: a frame end, a button press, or a
   // payload byte. Frame end and button may come together; payload comes alone.
   typedef struct packed {
      logic        has_frame_end;
      logic        has_button;
      logic        has_payload;
      logic [7:0]  data;
      logic [31:0] frame_number;
   } entry_type;

endpackage

>>> hw/rtl/cpfr_parser.sv
module cpfr_parser
   import cpfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic        cmd,
   input  logic [7:0]  data_byte,
   input  logic [10:0] packet_size,
   input  logic        packet_last,
   output logic        entry_valid,
   output entry_type   entry
);

   logic [10:0] position_ff, position_in;
   logic [15:0] stated_length_ff, stated_length_in;
   logic        rejected_ff, rejected_in;
   logic [7:0]  header_fid_ff, header_fid_in;
   logic [7:0]  header_camera_ff, header_camera_in;
   logic [7:0]  open_fid_ff, open_fid_in;
   logic [7:0]  open_camera_ff, open_camera_in;
   logic        frame_open_ff, frame_open_in;
   logic [31:0] frame_counter_ff, frame_counter_in;
   logic        payload_enable_ff, payload_enable_in;

   logic [15:0] new_length;
   logic [16:0] header_span;
   logic [16:0] payload_limit;
   logic        closing;
   logic        header_ok;

   assign new_length    = {data_byte, stated_length_ff[7:0]};
   assign header_span   = TRANSPORT_BYTES + {1'b0, new_length};
   assign payload_limit = TRANSPORT_BYTES + {1'b0, stated_length_ff};

   always_comb begin
      position_in       = position_ff;
      stated_length_in  = stated_length_ff;
      rejected_in       = rejected_ff;
      header_fid_in     = header_fid_ff;
      header_camera_in  = header_camera_ff;
      open_fid_in       = open_fid_ff;
      open_camera_in    = open_camera_ff;
      frame_open_in     = frame_open_ff;
      frame_counter_in  = frame_counter_ff;
      payload_enable_in = payload_enable_ff;
      entry             = '0;
      closing           = 1'b0;
      header_ok         = 1'b0;

      if (accept) begin
         if (cmd == CMD_FLUSH) begin
            if (frame_open_ff) begin
               entry.has_frame_end = 1'b1;
               entry.frame_number  = frame_counter_ff;
               frame_counter_in    = frame_counter_ff + 32'd1;
               frame_open_in       = 1'b0;
            end
         end else begin
            if (!rejected_ff) begin
               case (position_ff)
                  POS_MAGIC_LO: begin
                     if (data_byte != MAGIC_LO || packet_size > MAX_PACKET) begin
                        rejected_in = 1'b1;
                     end
                  end
                  POS_MAGIC_HI: begin
                     if (data_byte != MAGIC_HI) begin
                        rejected_in = 1'b1;
                     end
                  end
                  POS_CHANNEL: begin
                     if (data_byte != CHANNEL_A && data_byte != CHANNEL_B) begin
                        rejected_in = 1'b1;
                     end
                  end
                  POS_LENGTH_LO: begin
                     stated_length_in = {8'd0, data_byte};
                  end
                  POS_LENGTH_HI: begin
                     stated_length_in = new_length;
                     if (header_span > {6'd0, packet_size} || packet_size < MIN_PACKET_SIZE
                         || new_length < MIN_STATED_LENGTH) begin
                        rejected_in = 1'b1;
                     end
                  end
                  POS_FRAME_ID: begin
                     header_fid_in = data_byte;
                  end
                  POS_CAMERA: begin
                     header_camera_in = data_byte;
                  end
                  POS_FLAGS: begin
                     // A new frame id closes the open frame before anything else.
                     closing = frame_open_ff && (open_fid_ff != header_fid_ff);
                     if (closing) begin
                        entry.has_frame_end = 1'b1;
                        entry.frame_number  = frame_counter_ff;
                        frame_counter_in    = frame_counter_ff + 32'd1;
                        frame_open_in       = 1'b0;
                     end
                     if (!frame_open_ff || closing) begin
                        open_fid_in    = header_fid_ff;
                        open_camera_in = header_camera_ff;
                        header_ok      = header_camera_ff < CAMERA_LIMIT;
                     end else begin
                        header_ok = header_camera_ff == open_camera_ff;
                     end
                     if ((data_byte & FLAG_REJECT_MASK) != 8'd0) begin
                        header_ok = 1'b0;
                     end
                     if (!header_ok) begin
                        rejected_in = 1'b1;
                     end else begin
                        payload_enable_in = 1'b1;
                        entry.has_button  = data_byte[FLAG_BUTTON_BIT];
                     end
                  end
                  default: begin
                     if (payload_enable_ff && position_ff >= POS_PAYLOAD_START
                         && {6'd0, position_ff} < payload_limit) begin
                        entry.has_payload = 1'b1;
                        entry.data        = data_byte;
                        frame_open_in     = 1'b1;
                     end
                  end
               endcase
            end

            if (packet_last) begin
               position_in       = '0;
               rejected_in       = 1'b0;
               payload_enable_in = 1'b0;
            end else if (position_ff != POS_SATURATE) begin
               position_in = position_ff + 11'd1;
            end
         end
      end
   end

   assign entry_valid = entry.has_frame_end | entry.has_button | entry.has_payload;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff       <= '0;
         stated_length_ff  <= '0;
         rejected_ff       <= 1'b0;
         header_fid_ff     <= '0;
         header_camera_ff  <= '0;
         open_fid_ff       <= '0;
         open_camera_ff    <= '0;
         frame_open_ff     <= 1'b0;
         frame_counter_ff  <= '0;
         payload_enable_ff <= 1'b0;
      end else begin
         position_ff       <= position_in;
         stated_length_ff  <= stated_length_in;
         rejected_ff       <= rejected_in;
         header_fid_ff     <= header_fid_in;
         header_camera_ff  <= header_camera_in;
         open_fid_ff       <= open_fid_in;
         open_camera_ff    <= open_camera_in;
         frame_open_ff     <= frame_open_in;
         frame_counter_ff  <= frame_counter_in;
         payload_enable_ff <= payload_enable_in;
      end
   end

endmodule

>>> hw/rtl/cpfr_queue.sv
module cpfr_queue
   import cpfr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output entry_type head_entry,
   output logic      empty
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_SLOT  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   entry_type          slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = count_ff == FULL_COUNT;
   assign empty      = count_ff == '0;
   assign do_push    = push && !full;
   assign do_pop     = pop && !empty;
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count exceeds depth");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("queue count did not grow on a lone push");
   a_ptrs_meet_when_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers differ while empty");
`endif

endmodule

>>> hw/rtl/cpfr_emitter.sv
module cpfr_emitter
   import cpfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  entry_type   head_entry,
   input  logic        queue_empty,
   output logic        queue_pop,
   input  logic [15:0] stream_tag,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  kind,
   output logic [7:0]  payload,
   output logic [31:0] frame_number,
   output logic [15:0] source_tag,
   output logic        run_last
);

   logic      cur_valid_ff, cur_valid_in;
   entry_type cur_ff, cur_in;
   logic      two_left;
   logic      take;
   kind_type  cur_kind;

   // An entry holding both a frame end and a button press is sent in two
   // transfers; the frame end goes first.
   assign two_left  = cur_ff.has_frame_end && cur_ff.has_button;
   assign take      = !cur_valid_ff || (pop && !two_left);
   assign queue_pop = take && !queue_empty;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (take) begin
         cur_valid_in = !queue_empty;
         cur_in       = head_entry;
      end else if (pop) begin
         cur_in.has_frame_end = 1'b0;
      end
   end

   always_comb begin
      if (cur_ff.has_frame_end) begin
         cur_kind = KIND_FRAME_END;
      end else if (cur_ff.has_button) begin
         cur_kind = KIND_BUTTON;
      end else begin
         cur_kind = KIND_PAYLOAD;
      end
   end

   assign empty        = !cur_valid_ff;
   assign kind         = cur_kind;
   assign payload      = (cur_kind == KIND_PAYLOAD) ? cur_ff.data : 8'd0;
   assign frame_number = (cur_kind == KIND_FRAME_END) ? cur_ff.frame_number : 32'd0;
   assign source_tag   = (cur_kind == KIND_FRAME_END) ? stream_tag : 16'd0;
   assign run_last     = !two_left;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
   end

endmodule

>>> hw/rtl/camera_packet_frame_reassembler.sv
// Camera packet frame reassembler.
// Input channel: one packet byte (or a flush command) is transferred per
// clock when push is high and full is low; packet_size is held across the
// packet and packet_last marks its final byte.
// Result channel: while empty is low the oldest result is on the rsp_ ports;
// it is transferred when pop is high. rsp_run_last marks the last result
// caused by one input; an input may cause zero, one or two results.
// Configuration: csr_stream_tag is written when csr_valid is high (csr_ready
// is always high); write it only while no results are pending.
// Throughput: one input per clock while full is low. Each result is one
// transfer on the output, so an input producing a frame end and a button
// press holds the output for two transfers; the entry queue between parser
// and output stage absorbs that, and full rises only when the queue fills.
// Path: the edge that transfers an input writes its result into the queue;
// the output stage registers it from there when free or being popped.
// Reset: synchronous; clears the parser, the queue and the output stage; no
// frame is open and the frame counter starts at zero.
// When the receiver stalls, results wait in the output stage and the queue;
// once QUEUE_DEPTH entries are waiting, full stays high.
module camera_packet_frame_reassembler
   import cpfr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   input  logic [10:0] req_packet_size,
   input  logic        req_packet_last,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload,
   output logic [31:0] rsp_frame_number,
   output logic [15:0] rsp_source_tag,
   output logic        rsp_run_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_stream_tag
);

   logic [15:0] stream_tag_ff, stream_tag_in;
   logic        accept;
   logic        entry_valid;
   entry_type   entry;
   entry_type   head_entry;
   logic        queue_empty;
   logic        queue_pop;

   assign csr_ready     = 1'b1;
   assign stream_tag_in = (csr_valid && csr_ready) ? csr_stream_tag : stream_tag_ff;
   assign accept        = push && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_tag_ff <= '0;
      end else begin
         stream_tag_ff <= stream_tag_in;
      end
   end

   cpfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_cmd),
      .data_byte   (req_data_byte),
      .packet_size (req_packet_size),
      .packet_last (req_packet_last),
      .entry_valid (entry_valid),
      .entry       (entry)
   );

   cpfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (entry_valid),
      .push_entry (entry),
      .full       (full),
      .pop        (queue_pop),
      .head_entry (head_entry),
      .empty      (queue_empty)
   );

   cpfr_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .queue_empty  (queue_empty),
      .queue_pop    (queue_pop),
      .stream_tag   (stream_tag_ff),
      .empty        (empty),
      .pop          (pop),
      .kind         (rsp_kind),
      .payload      (rsp_payload),
      .frame_number (rsp_frame_number),
      .source_tag   (rsp_source_tag),
      .run_last     (rsp_run_last)
   );

`ifndef ASSERT_OFF
   a_payload_alone: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_kind == KIND_PAYLOAD |-> rsp_run_last)
      else $error("payload result not marked as last of its run");
   a_button_last: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_kind == KIND_BUTTON |-> rsp_run_last)
      else $error("button result not marked as last of its run");
   a_tag_only_on_end: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_kind != KIND_FRAME_END |-> rsp_frame_number == 32'd0
      && rsp_source_tag == 16'd0)
      else $error("frame fields set on a result that is not a frame end");
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      pop && !empty && !rsp_run_last |=> !empty && rsp_kind == KIND_BUTTON)
      else $error("second result of a run did not follow");
`endif

endmodule

>>> tb/sv/tb.sv
module tb
   import cpfr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      kind_type    kind;
      logic [7:0]  payload;
      logic [31:0] frame_number;
      logic [15:0] source_tag;
      logic        run_last;
   } rsp_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_cmd = CMD_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic [10:0] req_packet_size = 11'd0;
   logic        req_packet_last = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_payload;
   logic [31:0] rsp_frame_number;
   logic [15:0] rsp_source_tag;
   logic        rsp_run_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_stream_tag = 16'h0000;

   camera_packet_frame_reassembler u_dut (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_cmd          (req_cmd),
      .req_data_byte    (req_data_byte),
      .req_packet_size  (req_packet_size),
      .req_packet_last  (req_packet_last),
      .empty            (empty),
      .pop              (pop),
      .rsp_kind         (rsp_kind),
      .rsp_payload      (rsp_payload),
      .rsp_frame_number (rsp_frame_number),
      .rsp_source_tag   (rsp_source_tag),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_stream_tag   (csr_stream_tag)
   );

   // Shadow of the parser state, updated on every accepted input transfer.
   logic [10:0] rx_pos;
   logic [15:0] rx_len;
   logic        pkt_drop;
   logic [7:0]  hdr_fid;
   logic [7:0]  hdr_cam;
   logic [7:0]  cur_fid;
   logic [7:0]  cur_cam;
   logic        in_frame;
   logic [31:0] frame_seq;
   logic        pass_payload;
   logic [15:0] tag_reg;

   rsp_item_type pending_results[$];
   rsp_item_type step_out[2];
   int           step_count;
   rsp_item_type want_rsp;

   int          errors = 0;
   int          inputs_taken = 0;
   int          results_taken = 0;
   int          frames_closed = 0;
   int          buttons_seen = 0;
   int          config_writes = 0;
   int          idle_cycles = 0;
   bit          calm = 1'b0;
   bit          gaps_on = 1'b1;

   logic [7:0]  pkt_bytes[$];
   logic [7:0]  gen_fid = 8'h00;
   logic [7:0]  gen_cam = 8'h00;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void add_result(kind_type kind, logic [7:0] pay, logic [31:0] fnum,
                                      logic [15:0] tag);
      step_out[step_count].kind = kind;
      step_out[step_count].payload = pay;
      step_out[step_count].frame_number = fnum;
      step_out[step_count].source_tag = tag;
      step_out[step_count].run_last = 1'b0;
      step_count++;
   endfunction

   function automatic void finish_frame();
      if (in_frame) begin
         add_result(KIND_FRAME_END, 8'h00, frame_seq, tag_reg);
         frame_seq = frame_seq + 32'd1;
         in_frame = 1'b0;
      end
   endfunction

   // Works out the results of one accepted byte or flush and queues them.
   function automatic void reassemble_byte(logic cmd, logic [7:0] b, logic [10:0] size,
                                           logic last);
      logic [10:0] p;
      logic        ok;
      int          i;
      p = rx_pos;
      step_count = 0;
      if (cmd == CMD_FLUSH) begin
         finish_frame();
      end else begin
         if (!pkt_drop) begin
            case (p)
               POS_MAGIC_LO: begin
                  if (b != MAGIC_LO || size > MAX_PACKET) pkt_drop = 1'b1;
               end
               POS_MAGIC_HI: begin
                  if (b != MAGIC_HI) pkt_drop = 1'b1;
               end
               POS_CHANNEL: begin
                  if (b != CHANNEL_A && b != CHANNEL_B) pkt_drop = 1'b1;
               end
               POS_LENGTH_LO: begin
                  rx_len = {8'h00, b};
               end
               POS_LENGTH_HI: begin
                  rx_len[15:8] = b;
                  if (int'(rx_len) + 5 > int'(size) || size < MIN_PACKET_SIZE ||
                      rx_len < MIN_STATED_LENGTH) pkt_drop = 1'b1;
               end
               POS_FRAME_ID: begin
                  hdr_fid = b;
               end
               POS_CAMERA: begin
                  hdr_cam = b;
               end
               POS_FLAGS: begin
                  // A new frame id closes the open frame even if this header fails.
                  if (in_frame && cur_fid != hdr_fid) finish_frame();
                  if (!in_frame) begin
                     cur_fid = hdr_fid;
                     cur_cam = hdr_cam;
                     ok = (hdr_cam < CAMERA_LIMIT);
                  end else begin
                     ok = (hdr_cam == cur_cam);
                  end
                  if ((b & FLAG_REJECT_MASK) != 8'h00) ok = 1'b0;
                  if (!ok) begin
                     pkt_drop = 1'b1;
                  end else begin
                     pass_payload = 1'b1;
                     if (b[FLAG_BUTTON_BIT]) add_result(KIND_BUTTON, 8'h00, 32'd0, 16'h0000);
                  end
               end
               default: begin
                  if (pass_payload && p >= POS_PAYLOAD_START && int'(p) < int'(rx_len) + 5)
                  begin
                     add_result(KIND_PAYLOAD, b, 32'd0, 16'h0000);
                     in_frame = 1'b1;
                  end
               end
            endcase
         end
         if (last) begin
            rx_pos = 11'd0;
            pkt_drop = 1'b0;
            pass_payload = 1'b0;
         end else if (p != POS_SATURATE) begin
            rx_pos = p + 11'd1;
         end
      end
      if (step_count > 0) step_out[step_count - 1].run_last = 1'b1;
      for (i = 0; i < step_count; i++) pending_results.push_back(step_out[i]);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
         errors++;
      end
   endfunction

   // Prediction, result checking and the watchdog, all on sampled values.
   always @(posedge clock) begin
      if (reset) begin
         rx_pos = 11'd0;
         rx_len = 16'd0;
         pkt_drop = 1'b0;
         hdr_fid = 8'h00;
         hdr_cam = 8'h00;
         cur_fid = 8'h00;
         cur_cam = 8'h00;
         in_frame = 1'b0;
         frame_seq = 32'd0;
         pass_payload = 1'b0;
         tag_reg = 16'h0000;
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (csr_valid && csr_ready) begin
            tag_reg = csr_stream_tag;
            config_writes++;
            idle_cycles = 0;
         end
         if (push && !full) begin
            reassemble_byte(req_cmd, req_data_byte, req_packet_size, req_packet_last);
            inputs_taken++;
            idle_cycles = 0;
         end
         if (pop && !empty) begin
            results_taken++;
            idle_cycles = 0;
            if (pending_results.size() == 0) begin
               $error("result with nothing expected: kind %0d payload 'h%0h frame %0d",
                      rsp_kind, rsp_payload, rsp_frame_number);
               errors++;
            end else begin
               want_rsp = pending_results.pop_front();
               check_field("rsp_kind", 32'(want_rsp.kind), 32'(rsp_kind));
               check_field("rsp_payload", 32'(want_rsp.payload), 32'(rsp_payload));
               check_field("rsp_frame_number", want_rsp.frame_number, rsp_frame_number);
               check_field("rsp_source_tag", 32'(want_rsp.source_tag), 32'(rsp_source_tag));
               check_field("rsp_run_last", 32'(want_rsp.run_last), 32'(rsp_run_last));
               if (want_rsp.kind == KIND_FRAME_END) frames_closed++;
               if (want_rsp.kind == KIND_BUTTON) buttons_seen++;
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Receiver: random stalls, none in the final phase.
   initial begin
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 11) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(0, 18)) @(negedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic idle_input(input int cycles);
      @(negedge clock);
      push <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_item(input logic cmd, input logic [7:0] data, input logic [10:0] size,
                            input logic last);
      if (!calm && gaps_on && $urandom_range(0, 11) == 0) idle_input($urandom_range(1, 19));
      @(negedge clock);
      push <= 1'b1;
      req_cmd <= cmd;
      req_data_byte <= data;
      req_packet_size <= size;
      req_packet_last <= last;
      do @(posedge clock); while (full);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      push <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_stream_tag(input logic [15:0] value);
      wait_until_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_stream_tag <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic build_packet(input logic [7:0] chan, input logic [15:0] stated,
                               input logic [7:0] fid, input logic [7:0] cam,
                               input logic [7:0] flags, input int body);
      int i;
      pkt_bytes.delete();
      pkt_bytes.push_back(MAGIC_LO);
      pkt_bytes.push_back(MAGIC_HI);
      pkt_bytes.push_back(chan);
      pkt_bytes.push_back(stated[7:0]);
      pkt_bytes.push_back(stated[15:8]);
      pkt_bytes.push_back(fid);
      pkt_bytes.push_back(cam);
      pkt_bytes.push_back(flags);
      // Four sensor bytes, then the body.
      for (i = 0; i < 4 + body; i++) pkt_bytes.push_back(8'($urandom));
   endtask

   task automatic send_packet(input logic [10:0] size, input bit jitter, input bit with_last);
      int i;
      for (i = 0; i < pkt_bytes.size(); i++) begin
         send_item(CMD_BYTE, pkt_bytes[i], jitter ? 11'($urandom) : size,
                   with_last && (i == pkt_bytes.size() - 1));
      end
   endtask

   task automatic send_flush();
      send_item(CMD_FLUSH, 8'($urandom), 11'($urandom), 1'($urandom));
   endtask

   task automatic test_frames_and_buttons();
      set_stream_tag(16'hFFFF);
      build_packet(CHANNEL_A, 16'd9, 8'h00, 8'h00, 8'h00, 2);
      pkt_bytes[12] = 8'h00;
      pkt_bytes[13] = 8'hFF;
      send_packet(11'(pkt_bytes.size()), 1'b0, 1'b1);
      // Same frame, channel 11, with a button press.
      build_packet(CHANNEL_B, 16'd9, 8'h00, 8'h00, 8'h02, 2);
      send_packet(11'(pkt_bytes.size()), 1'b0, 1'b1);
      // New frame id with a button: frame end and button come from one byte.
      build_packet(CHANNEL_A, 16'd8, 8'hFF, 8'h00, 8'h02, 1);
      send_packet(11'(pkt_bytes.size()), 1'b0, 1'b1);
      send_flush();
      send_flush();
      build_packet(CHANNEL_B, 16'd8, 8'h01, 8'h01, 8'h00, 1);
      send_packet(11'(pkt_bytes.size()), 1'b0, 1'b1);
      // Header only, no payload, under a new frame id.
      build_packet(CHANNEL_A, 16'd7, 8'h02, 8'h01, 8'h00, 0);
      send_packet(11'(pkt_bytes.size()), 1'b0, 1'b1);
      send_flush();
   endtask

   task automatic test_header_checks();
      logic [10:0] sz;
      set_stream_tag(16'h0000);
      for (int k = 0; k < 10; k++) begin
         build_packet(CHANNEL_A, 16'd9, 8'h10, 8'h00, 8'h00, 2);
         sz = 11'(pkt_bytes.size());
         case (k)
            0: pkt_bytes[0] = 8'hAB;
            1: pkt_bytes[1] = 8'hBA;
            2: pkt_bytes[2] = 8'h08;
            3: pkt_bytes[3] = 8'h06;
            4: pkt_bytes[7] = 8'h01;
            5: pkt_bytes[7] = 8'hFC;
            6: pkt_bytes[6] = 8'h02;
            7: sz = 11'd13;
            8: sz = 11'h7FF;
            default: begin
               while (pkt_bytes.size() > 6) void'(pkt_bytes.pop_back());
            end
         endcase
         send_packet(sz, 1'b0, 1'b1);
         // A good packet after each bad one; the largest legal size on it.
         build_packet(CHANNEL_A, 16'd8, 8'h10, 8'h00, 8'h00, 1);
         send_packet(MAX_PACKET, 1'b0, 1'b1);
      end
      // Camera differs from the one of the open frame.
      build_packet(CHANNEL_A, 16'd8, 8'h10, 8'h01, 8'h00, 1);
      send_packet(11'(pkt_bytes.size()), 1'b0, 1'b1);
      send_flush();
   endtask

   task automatic test_trailing_bytes();
      // Stated length covers two payload bytes; the rest of the packet is ignored.
      build_packet(CHANNEL_B, 16'd9, 8'h20, 8'h01, 8'h00, 6);
      send_packet(11'(pkt_bytes.size() + 3), 1'b0, 1'b1);
      send_flush();
   endtask

   task automatic test_missing_last();
      int i;
      build_packet(CHANNEL_A, 16'd27, 8'h30, 8'h00, 8'h00, 20);
      for (i = 0; i < 40; i++) pkt_bytes.push_back(8'($urandom));
      // No final byte marker: the position keeps counting past the packet.
      send_packet(11'd32, 1'b0, 1'b0);
      send_item(CMD_BYTE, 8'($urandom), 11'd32, 1'b1);
      build_packet(CHANNEL_A, 16'd8, 8'h30, 8'h00, 8'h00, 1);
      send_packet(11'(pkt_bytes.size()), 1'b0, 1'b1);
      send_flush();
   endtask

   task automatic random_packet();
      int          pick;
      int          body;
      int          n;
      logic [7:0]  cam;
      logic [7:0]  flags;
      logic [15:0] stated;
      logic [10:0] sz;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) gaps_on = ~gaps_on;
      if (pick < 8) begin
         send_flush();
      end else begin
         body = ($urandom_range(0, 63) == 0) ? $urandom_range(25, 1012) : $urandom_range(0, 24);
         stated = 16'(7 + body);
         if ($urandom_range(0, 4) == 0) begin
            gen_fid = $urandom_range(0, 1) ? gen_fid + 8'd1 : 8'($urandom);
            gen_cam = 8'($urandom_range(0, 1));
         end
         cam = ($urandom_range(0, 9) == 0) ? 8'($urandom) : gen_cam;
         case ($urandom_range(0, 15))
            0, 1, 2, 3: flags = 8'h02;
            4: flags = 8'($urandom);
            5: flags = 8'h01;
            default: flags = 8'h00;
         endcase
         build_packet($urandom_range(0, 1) ? CHANNEL_A : CHANNEL_B, stated, gen_fid, cam, flags,
                      body);
         n = pkt_bytes.size();
         sz = 11'(n);
         if (pick < 70) begin
            if ($urandom_range(0, 5) == 0) begin
               stated = 16'(7 + $urandom_range(0, body));
               pkt_bytes[3] = stated[7:0];
               pkt_bytes[4] = stated[15:8];
            end
            if ($urandom_range(0, 3) == 0) begin
               sz = 11'((n + 8 > 1024) ? 1024 : n + $urandom_range(0, 8));
            end
            send_packet(sz, 1'b0, 1'b1);
         end else begin
            case ($urandom_range(0, 5))
               0: begin
                  pkt_bytes[$urandom_range(0, 7)] = 8'($urandom);
                  send_packet(sz, 1'b0, 1'b1);
               end
               1: begin
                  n = $urandom_range(1, 7);
                  while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
                  send_packet(sz, 1'b0, 1'b1);
               end
               2: send_packet(11'($urandom_range(1025, 2047)), 1'b0, 1'b1);
               3: send_packet(11'($urandom_range(0, 2047)), 1'b0, 1'b1);
               4: begin
                  n = $urandom_range(1, 20);
                  pkt_bytes.delete();
                  repeat (n) pkt_bytes.push_back(8'($urandom));
                  send_packet(11'($urandom), 1'b0, 1'b1);
               end
               default: send_packet(sz, 1'b1, 1'b1);
            endcase
         end
      end
   endtask

   task automatic test_random_traffic(input int count, input bit quiet);
      int stop_at;
      calm = quiet;
      stop_at = inputs_taken + count;
      while (inputs_taken < stop_at) random_packet();
      // Hold the sender until everything of this phase has come out.
      wait_until_drained();
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_frames_and_buttons();
      test_header_checks();
      test_trailing_bytes();
      test_missing_last();
      set_stream_tag(16'($urandom));
      test_random_traffic(450, 1'b0);
      set_stream_tag(16'h8001);
      test_random_traffic(450, 1'b0);
      set_stream_tag(16'($urandom));
      test_random_traffic(350, 1'b1);
      wait_until_drained();
      $display("Covered %0d input transfers and %0d result transfers:",
               inputs_taken, results_taken);
      $display("%0d frame ends, %0d buttons, %0d stream tag writes; no idling at the end.",
               frames_closed, buttons_seen, config_writes);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
